>>> rtl/sfss_pkg.sv
// ----------------------------------------------------------------------------
// sfss_pkg
// Shared types, constants and the coil drive table for the full-step sequencer.
// ----------------------------------------------------------------------------
package sfss_pkg;

    localparam int STEPS_W    = 16;
    localparam int TICK_W     = 20;
    localparam int PHASE_W    = 2;
    localparam int COIL_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [TICK_W-1:0]  TICK_MAX          = '1;
    localparam logic [TICK_W-1:0]  STEP_INTERVAL_RST = TICK_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_FWD         = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PHASE_REV         = PHASE_W'(3);

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    localparam logic REG_STEP_INTERVAL = 1'b0;

    typedef struct packed {
        logic [COIL_W-1:0]  coil;
        logic               stepped;
        logic               busy;
        logic [STEPS_W-1:0] steps;
    } t_result;

    // Bit 3 is A+, bit 2 is A-, bit 1 is B+, bit 0 is B-.
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pattern;
        case (phase)
            2'd0:    pattern = 4'b1010;
            2'd1:    pattern = 4'b0110;
            2'd2:    pattern = 4'b0101;
            default: pattern = 4'b1001;
        endcase
        return pattern;
    endfunction

endpackage

>>> rtl/sfss_core.sv
// ----------------------------------------------------------------------------
// sfss_core
// Step pacing state: phase, direction, remaining count, tick counter and the
// held coil drive, updated once for every accepted word.
// ----------------------------------------------------------------------------
module sfss_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic signed [sfss_pkg::STEPS_W-1:0] i_move_steps,
    input  logic [sfss_pkg::TICK_W-1:0]   i_step_interval,
    output sfss_pkg::t_result             o_result
);

    logic [sfss_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic                         r_dir_ccw, n_dir_ccw;
    logic [sfss_pkg::STEPS_W-1:0] r_steps_left, n_steps_left;
    logic [sfss_pkg::TICK_W-1:0]  r_tick_elapsed, n_tick_elapsed;
    logic [sfss_pkg::COIL_W-1:0]  r_coil, n_coil;

    logic [sfss_pkg::STEPS_W-1:0] raw;
    logic [sfss_pkg::TICK_W-1:0]  tick_inc;
    logic                         stepped;

    assign raw = i_move_steps;

    always_comb begin
        n_phase        = r_phase;
        n_dir_ccw      = r_dir_ccw;
        n_steps_left   = r_steps_left;
        n_tick_elapsed = r_tick_elapsed;
        n_coil         = r_coil;
        stepped        = 1'b0;
        tick_inc       = (r_tick_elapsed != sfss_pkg::TICK_MAX) ?
                         r_tick_elapsed + sfss_pkg::TICK_W'(1) : r_tick_elapsed;
        if (i_req_type == sfss_pkg::REQ_MOVE) begin
            n_dir_ccw    = raw[sfss_pkg::STEPS_W-1] || (raw == '0);
            n_steps_left = raw[sfss_pkg::STEPS_W-1] ? (~raw + sfss_pkg::STEPS_W'(1)) : raw;
        end else begin
            n_tick_elapsed = tick_inc;
            if ((r_steps_left != '0) && (tick_inc >= i_step_interval)) begin
                n_coil         = sfss_pkg::coil_of(r_phase);
                n_phase        = r_phase + (r_dir_ccw ? sfss_pkg::PHASE_REV
                                                      : sfss_pkg::PHASE_FWD);
                n_tick_elapsed = '0;
                n_steps_left   = r_steps_left - sfss_pkg::STEPS_W'(1);
                stepped        = 1'b1;
            end
        end
    end

    assign o_result.coil    = n_coil;
    assign o_result.stepped = stepped;
    assign o_result.busy    = (n_steps_left != '0);
    assign o_result.steps   = n_steps_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= '0;
            r_dir_ccw      <= 1'b0;
            r_steps_left   <= '0;
            r_tick_elapsed <= '0;
            r_coil         <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_dir_ccw      <= n_dir_ccw;
            r_steps_left   <= n_steps_left;
            r_tick_elapsed <= n_tick_elapsed;
            r_coil         <= n_coil;
        end
    end

endmodule

>>> rtl/sfss_out_q.sv
// ----------------------------------------------------------------------------
// sfss_out_q
// Two-entry result queue that lets a new word enter while the previous result
// still waits at the output.
// ----------------------------------------------------------------------------
module sfss_out_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfss_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output sfss_pkg::t_result o_data
);

    sfss_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/stepper_full_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer
// Paced four-phase full-step driver for two H-bridge coil pairs.
//
//   channel   direction  handshake             payload
//   request   in         i_valid / o_ready     i_req_type, i_move_steps
//   result    out        o_valid / i_ready     coil drives, stepped, busy, count
//   config    in         psel/penable/pready   paddr, pwdata, prdata
//
// Each word is processed in the cycle it is accepted, and its result is
// registered and shown at the output once earlier results are taken; one
// result per word, one word per cycle while results are taken. The two-entry
// queue lowers o_ready only when both entries wait on a stalled output.
// Synchronous active-low reset clears all stepping state and the queue;
// step_interval resets to one.
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic signed [sfss_pkg::STEPS_W-1:0] i_move_steps,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_coil_a_pos,
    output logic                               o_coil_a_neg,
    output logic                               o_coil_b_pos,
    output logic                               o_coil_b_neg,
    output logic                               o_stepped,
    output logic                               o_busy_res,
    output logic [sfss_pkg::STEPS_W-1:0]       o_steps_remaining,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfss_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sfss_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sfss_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    logic [sfss_pkg::TICK_W-1:0] r_step_interval;
    logic                        q_full;
    logic                        accept;
    sfss_pkg::t_result           core_result;
    sfss_pkg::t_result           out_result;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == sfss_pkg::REG_STEP_INTERVAL) ?
                     sfss_pkg::APB_DATA_W'(r_step_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= sfss_pkg::STEP_INTERVAL_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == sfss_pkg::REG_STEP_INTERVAL)) begin
            r_step_interval <= pwdata[sfss_pkg::TICK_W-1:0];
        end
    end

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    sfss_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_req_type),
        .i_move_steps    (i_move_steps),
        .i_step_interval (r_step_interval),
        .o_result        (core_result)
    );

    sfss_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_result)
    );

    assign o_coil_a_pos      = out_result.coil[3];
    assign o_coil_a_neg      = out_result.coil[2];
    assign o_coil_b_pos      = out_result.coil[1];
    assign o_coil_b_neg      = out_result.coil[0];
    assign o_stepped         = out_result.stepped;
    assign o_busy_res        = out_result.busy;
    assign o_steps_remaining = out_result.steps;

endmodule

>>> rtl/sfss_checker.sv
// ----------------------------------------------------------------------------
// sfss_checker
// Port-level checks of the full-step sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sfss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_coil_a_pos,
    input logic                         o_coil_a_neg,
    input logic                         o_coil_b_pos,
    input logic                         o_coil_b_neg,
    input logic                         o_stepped,
    input logic                         o_busy_res,
    input logic [sfss_pkg::STEPS_W-1:0] o_steps_remaining
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_busy_res == (o_steps_remaining != '0)))
        else $error("busy flag disagrees with remaining count");

    a_step_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stepped) |->
        ((o_coil_a_pos ^ o_coil_a_neg) && (o_coil_b_pos ^ o_coil_b_neg)))
        else $error("step taken without a full coil pattern");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_steps_remaining)))
        else $error("stalled result changed");

endmodule

bind stepper_full_step_sequencer sfss_checker u_sfss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_coil_a_pos      (o_coil_a_pos),
    .o_coil_a_neg      (o_coil_a_neg),
    .o_coil_b_pos      (o_coil_b_pos),
    .o_coil_b_neg      (o_coil_b_neg),
    .o_stepped         (o_stepped),
    .o_busy_res        (o_busy_res),
    .o_steps_remaining (o_steps_remaining)
);

>>> bench/tb_stepper_full_step_sequencer.sv
// ----------------------------------------------------------------------------
// tb_stepper_full_step_sequencer
// Self-checking bench for the paced full-step coil sequencer. Each request
// word is mirrored into a cycle-free model of the phase, count and tick
// state, and every result word is compared field by field with the oldest
// expected result. Directed tests cover signs, extremes and intervals,
// and three random runs under varying back-pressure and interval settings
// follow.
// ----------------------------------------------------------------------------
module tb_stepper_full_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_LIMIT = 200;
    localparam logic [sfss_pkg::APB_ADDR_W-1:0] ADDR_STEP_INTERVAL =
        {sfss_pkg::REG_STEP_INTERVAL, 2'b00};
    localparam logic [sfss_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
        {~sfss_pkg::REG_STEP_INTERVAL, 2'b00};
    localparam logic [15:0] COIL_SEQ = 16'h956A;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_req_type = sfss_pkg::REQ_TICK;
    logic signed [sfss_pkg::STEPS_W-1:0] i_move_steps = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_coil_a_pos;
    logic                  o_coil_a_neg;
    logic                  o_coil_b_pos;
    logic                  o_coil_b_neg;
    logic                  o_stepped;
    logic                  o_busy_res;
    logic [sfss_pkg::STEPS_W-1:0]    o_steps_remaining;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [sfss_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [sfss_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [sfss_pkg::APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [sfss_pkg::TICK_W-1:0]  m_interval = sfss_pkg::STEP_INTERVAL_RST;
    logic [sfss_pkg::PHASE_W-1:0] m_phase = '0;
    logic                         m_ccw = 1'b0;
    logic [sfss_pkg::STEPS_W-1:0] m_left = '0;
    logic [sfss_pkg::TICK_W-1:0]  m_elapsed = '0;
    logic [sfss_pkg::COIL_W-1:0]  m_coil = '0;

    sfss_pkg::t_result pending_drive[$];
    int      n_bad = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    stepper_full_step_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_move_steps      (i_move_steps),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_coil_a_pos      (o_coil_a_pos),
        .o_coil_a_neg      (o_coil_a_neg),
        .o_coil_b_pos      (o_coil_b_pos),
        .o_coil_b_neg      (o_coil_b_neg),
        .o_stepped         (o_stepped),
        .o_busy_res        (o_busy_res),
        .o_steps_remaining (o_steps_remaining),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    function automatic sfss_pkg::t_result next_drive(input logic req,
                                                     input logic [sfss_pkg::STEPS_W-1:0] count);
        sfss_pkg::t_result r;
        r.stepped = 1'b0;
        if (req == sfss_pkg::REQ_MOVE) begin
            m_ccw  = !($signed(count) > 0);
            m_left = count[sfss_pkg::STEPS_W-1] ? (16'd0 - count) : count;
        end else begin
            if (m_elapsed != sfss_pkg::TICK_MAX)
                m_elapsed = m_elapsed + 1'b1;
            if (m_left != 0 && m_elapsed >= m_interval) begin
                m_coil    = COIL_SEQ[4*m_phase +: 4];
                m_phase   = m_phase + (m_ccw ? sfss_pkg::PHASE_REV : sfss_pkg::PHASE_FWD);
                m_elapsed = '0;
                m_left    = m_left - 1'b1;
                r.stepped = 1'b1;
            end
        end
        r.coil  = m_coil;
        r.busy  = (m_left != 0);
        r.steps = m_left;
        return r;
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        n_bad++;
        if (n_bad <= PRINT_LIMIT)
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        sfss_pkg::t_result want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_STEP_INTERVAL)
                m_interval = pwdata[sfss_pkg::TICK_W-1:0];
            if (i_valid && o_ready)
                pending_drive.push_back(next_drive(i_req_type, i_move_steps));
            if (o_valid && i_ready) begin
                if (pending_drive.size() == 0) begin
                    n_bad++;
                    if (n_bad <= PRINT_LIMIT)
                        $display("%0t: result word with none expected", $time);
                end else begin
                    want = pending_drive.pop_front();
                    if (o_coil_a_pos !== want.coil[3])
                        report_field("coil_a_pos", want.coil[3], o_coil_a_pos);
                    if (o_coil_a_neg !== want.coil[2])
                        report_field("coil_a_neg", want.coil[2], o_coil_a_neg);
                    if (o_coil_b_pos !== want.coil[1])
                        report_field("coil_b_pos", want.coil[1], o_coil_b_pos);
                    if (o_coil_b_neg !== want.coil[0])
                        report_field("coil_b_neg", want.coil[0], o_coil_b_neg);
                    if (o_stepped !== want.stepped)
                        report_field("stepped", want.stepped, o_stepped);
                    if (o_busy_res !== want.busy)
                        report_field("busy_res", want.busy, o_busy_res);
                    if (o_steps_remaining !== want.steps)
                        report_field("steps_remaining", want.steps, o_steps_remaining);
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_word(input logic req, input logic [sfss_pkg::STEPS_W-1:0] count);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_move_steps <= count;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_tick();
        send_word(sfss_pkg::REQ_TICK, 16'($urandom));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_drive.size() != 0);
    endtask

    task automatic write_reg(input logic [sfss_pkg::APB_ADDR_W-1:0] addr,
                             input logic [sfss_pkg::TICK_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {12'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_power_up();
        send_tick();
        send_tick();
    endtask

    task automatic test_move_sign();
        send_word(sfss_pkg::REQ_MOVE, 16'sd2);
        repeat (3) send_tick();
        send_word(sfss_pkg::REQ_MOVE, -16'sd32768);
        send_tick();
        send_word(sfss_pkg::REQ_MOVE, 16'sd0);
        send_tick();
        send_word(sfss_pkg::REQ_MOVE, 16'sd32767);
        send_word(sfss_pkg::REQ_MOVE, -16'sd1);
        repeat (2) send_tick();
    endtask

    task automatic test_zero_interval();
        write_reg(ADDR_STEP_INTERVAL, '0);
        send_word(sfss_pkg::REQ_MOVE, 16'sd3);
        repeat (2) send_tick();
    endtask

    task automatic test_paced_interval();
        write_reg(ADDR_STEP_INTERVAL, 20'd3);
        send_word(sfss_pkg::REQ_MOVE, -16'sd2);
        repeat (5) send_tick();
    endtask

    task automatic test_unmapped_address();
        write_reg(ADDR_UNMAPPED, '0);
        send_word(sfss_pkg::REQ_MOVE, 16'sd1);
        repeat (2) send_tick();
    endtask

    task automatic test_long_interval();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ADDR_STEP_INTERVAL, sfss_pkg::TICK_MAX);
        send_word(sfss_pkg::REQ_MOVE, 16'sd2);
        repeat (4) send_tick();
        write_reg(ADDR_STEP_INTERVAL, 20'd2);
        repeat (3) send_tick();
    endtask

    task automatic test_random_moves(input int sender_pct, input int receiver_pct);
        logic [sfss_pkg::TICK_W-1:0]  interval;
        logic [sfss_pkg::STEPS_W-1:0] count;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (7) begin
            case ($urandom_range(9, 0))
                0:       interval = '0;
                1:       interval = 20'd1;
                7, 8:    interval = 20'($urandom_range(30, 7));
                9:       interval = sfss_pkg::TICK_MAX;
                default: interval = 20'($urandom_range(6, 2));
            endcase
            write_reg(ADDR_STEP_INTERVAL, interval);
            repeat (90) begin
                if ($urandom_range(99, 0) < 12) begin
                    case ($urandom_range(9, 0))
                        0, 1: count = 16'($urandom);
                        2: count = 16'h8000;
                        3: count = 16'h7FFF;
                        4: count = 16'hFFFF;
                        5: count = 16'h0000;
                        default: begin
                            count = 16'($urandom_range(24, 1));
                            if ($urandom_range(1, 0))
                                count = 16'd0 - count;
                        end
                    endcase
                    send_word(sfss_pkg::REQ_MOVE, count);
                end else begin
                    send_tick();
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 18;
        recv_idle_pct = 49;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_up();
        test_move_sign();
        test_zero_interval();
        test_paced_interval();
        test_unmapped_address();
        test_long_interval();
        test_random_moves(18, 49);
        test_random_moves(49, 18);
        test_random_moves(0, 0);
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_bad == 0 && pending_drive.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
